@@ hdl/lns_pkg.sv @@
`default_nettype none
package lns_pkg;

    // Argument and result formats.
    localparam int X_W      = 32;
    localparam int LOG_W    = 20;
    localparam int FRAC_E   = 30;
    localparam int MAG_W    = 30;
    localparam int SUM_W    = 32;
    localparam int DEN_W    = 32;

    // One in Q15.16.
    localparam logic [X_W-1:0] ONE_Q16 = 32'h0001_0000;

    // Divider: two quotient bits per stage.
    localparam int DIV_Q_BITS = MAG_W;
    localparam int DIV_STEP   = 2;
    localparam int DIV_STAGES = DIV_Q_BITS / DIV_STEP;

    // Reciprocal scale for division of a term by its odd index.
    localparam int RECIP_SHIFT = 31;
    localparam int RECIP_W     = 32;

    localparam logic signed [LOG_W-1:0] LOG_MAX = 20'sh7FFFF;
    localparam logic [LOG_W-1:0] LOG_MIN_MAG    = 20'h80000;

    // Flags that ride along with each word through the pipeline.
    typedef struct packed {
        logic err;
        logic below_one;
    } side_t;

endpackage
`default_nettype wire

@@ hdl/natural_log_series_top.sv @@
// Natural logarithm of a signed Q15.16 word by the atanh series
// ln(x) = 2 * sum(e^i / i) over odd i, with e = (x-1)/(x+1) held in Q1.30.
// The block is a stall-as-a-whole pipeline: it takes one word per cycle and
// returns one result word per input word, in order. It has one input stage,
// fifteen divider stages at two quotient bits each, one squaring stage, two
// stages for each of the N = (LAST_ODD_POWER+1)/2 series terms (a reciprocal
// multiply and the power update, then the quotient correction and
// accumulation) and the output register. When the output word is not taken,
// every stage holds. A zero or negative argument gives log_value 0 with
// domain_error set; other results are truncated toward zero and saturated to
// the 20-bit field. Arithmetic is done on magnitudes, so x below one simply
// negates the final value.
`default_nettype none
module natural_log_series_top
    import lns_pkg::*;
#(
    parameter int LAST_ODD_POWER = 25
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic signed [X_W-1:0]   x_value,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic signed [LOG_W-1:0]      log_value,
    output logic                         domain_error
);

    localparam int NUM_TERMS = (LAST_ODD_POWER + 1) / 2;

    // Output stage.
    logic                       out_valid_reg;
    logic signed [LOG_W-1:0]    log_value_reg;
    logic                       domain_error_reg;
    logic signed [LOG_W-1:0]    log_value_next;
    logic [LOG_W-1:0]           lmag;

    // The whole pipeline moves when the output register is free or emptying.
    logic advance;
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    // Input stage: domain check, numerator and denominator of e.
    logic             s0_valid_reg;
    side_t            s0_side_reg;
    logic [DEN_W-1:0] s0_diff_reg;
    logic [DEN_W-1:0] s0_den_reg;
    side_t            s0_side_next;
    logic [DEN_W-1:0] s0_diff_next;
    logic [DEN_W-1:0] s0_den_next;

    always_comb
    begin
        s0_side_next.err       = x_value[X_W-1] || (x_value == '0);
        s0_side_next.below_one = (x_value < ONE_Q16);
        s0_diff_next = s0_side_next.below_one ? (ONE_Q16 - x_value) : (x_value - ONE_Q16);
        s0_den_next  = x_value + ONE_Q16;
    end

    // Divider output and squaring stage.
    logic                  d_valid;
    side_t                 d_side;
    logic [MAG_W-1:0]      d_quo;
    logic [2*MAG_W-1:0]    sq_prod;

    logic                  s1_valid_reg;
    side_t                 s1_side_reg;
    logic [MAG_W-1:0]      s1_mag_reg;
    logic [MAG_W-1:0]      s1_e2_reg;

    assign sq_prod = {{MAG_W{1'b0}}, d_quo} * {{MAG_W{1'b0}}, d_quo};

    // Term chain.
    logic              t_valid [NUM_TERMS+1];
    side_t             t_side  [NUM_TERMS+1];
    logic [MAG_W-1:0]  t_power [NUM_TERMS+1];
    logic [MAG_W-1:0]  t_e2    [NUM_TERMS+1];
    logic [SUM_W-1:0]  t_sum   [NUM_TERMS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s0_valid_reg  <= in_valid;
            s1_valid_reg  <= d_valid;
            out_valid_reg <= t_valid[NUM_TERMS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_side_reg      <= s0_side_next;
            s0_diff_reg      <= s0_diff_next;
            s0_den_reg       <= s0_den_next;
            s1_side_reg      <= d_side;
            s1_mag_reg       <= d_quo;
            s1_e2_reg        <= sq_prod[FRAC_E +: MAG_W];
            log_value_reg    <= log_value_next;
            domain_error_reg <= t_side[NUM_TERMS].err;
        end
    end

    lns_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (s0_valid_reg),
        .in_side   (s0_side_reg),
        .in_rem    (s0_diff_reg),
        .in_den    (s0_den_reg),
        .out_valid (d_valid),
        .out_side  (d_side),
        .out_quo   (d_quo)
    );

    assign t_valid[0] = s1_valid_reg;
    assign t_side[0]  = s1_side_reg;
    assign t_power[0] = s1_mag_reg;
    assign t_e2[0]    = s1_e2_reg;
    assign t_sum[0]   = '0;

    genvar k;
    generate
        for (k = 0; k < NUM_TERMS; k++) begin : g_term
            lns_term #(
                .ODD_INDEX (2*k + 1)
            ) u_term (
                .clk       (clk),
                .rst_n     (rst_n),
                .advance   (advance),
                .in_valid  (t_valid[k]),
                .in_side   (t_side[k]),
                .in_power  (t_power[k]),
                .in_e2     (t_e2[k]),
                .in_sum    (t_sum[k]),
                .out_valid (t_valid[k+1]),
                .out_side  (t_side[k+1]),
                .out_power (t_power[k+1]),
                .out_e2    (t_e2[k+1]),
                .out_sum   (t_sum[k+1])
            );
        end
    endgenerate

    // Doubling the Q1.30 sum and moving to Q15.16 is a right shift by 13.
    assign lmag = {1'b0, t_sum[NUM_TERMS][SUM_W-1:FRAC_E-16-1]};

    always_comb
    begin
        if (t_side[NUM_TERMS].err)
        begin
            log_value_next = '0;
        end
        else if (t_side[NUM_TERMS].below_one)
        begin
            log_value_next = (lmag > LOG_MIN_MAG) ? $signed(LOG_MIN_MAG)
                                                  : -$signed(lmag);
        end
        else
        begin
            log_value_next = (lmag > LOG_W'(LOG_MAX)) ? LOG_MAX : $signed(lmag);
        end
    end

    assign out_valid    = out_valid_reg;
    assign log_value    = log_value_reg;
    assign domain_error = domain_error_reg;

endmodule
`default_nettype wire

@@ hdl/lns_divider.sv @@
`default_nettype none
module lns_divider
    import lns_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  advance,
    input  wire logic                  in_valid,
    input  wire side_t                 in_side,
    input  wire logic [DEN_W-1:0]      in_rem,
    input  wire logic [DEN_W-1:0]      in_den,
    output logic                       out_valid,
    output side_t                      out_side,
    output logic [DIV_Q_BITS-1:0]      out_quo
);

    // Restoring division; the initial remainder is already below the divisor,
    // so each step shifts in a zero and subtracts where it fits.
    logic                  valid_reg [DIV_STAGES];
    side_t                 side_reg  [DIV_STAGES];
    logic [DEN_W-1:0]      rem_reg   [DIV_STAGES];
    logic [DEN_W-1:0]      den_reg   [DIV_STAGES];
    logic [DIV_Q_BITS-1:0] quo_reg   [DIV_STAGES];

    genvar g;
    generate
        for (g = 0; g < DIV_STAGES; g++) begin : g_stage
            logic                  src_valid;
            side_t                 src_side;
            logic [DEN_W-1:0]      src_rem;
            logic [DEN_W-1:0]      src_den;
            logic [DIV_Q_BITS-1:0] src_quo;
            logic [DEN_W-1:0]      rem_next;
            logic [DIV_Q_BITS-1:0] quo_next;

            if (g == 0) begin : g_first
                assign src_valid = in_valid;
                assign src_side  = in_side;
                assign src_rem   = in_rem;
                assign src_den   = in_den;
                assign src_quo   = '0;
            end else begin : g_rest
                assign src_valid = valid_reg[g-1];
                assign src_side  = side_reg[g-1];
                assign src_rem   = rem_reg[g-1];
                assign src_den   = den_reg[g-1];
                assign src_quo   = quo_reg[g-1];
            end

            always_comb
            begin
                logic [DEN_W:0] t;
                rem_next = src_rem;
                quo_next = src_quo;
                for (int j = 0; j < DIV_STEP; j++)
                begin
                    t = {rem_next, 1'b0};
                    if (t >= {1'b0, src_den})
                    begin
                        t        = t - {1'b0, src_den};
                        quo_next = {quo_next[DIV_Q_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        quo_next = {quo_next[DIV_Q_BITS-2:0], 1'b0};
                    end
                    rem_next = t[DEN_W-1:0];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[g] <= 1'b0;
                end
                else if (advance)
                begin
                    valid_reg[g] <= src_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    side_reg[g] <= src_side;
                    rem_reg[g]  <= rem_next;
                    den_reg[g]  <= src_den;
                    quo_reg[g]  <= quo_next;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];
    assign out_quo   = quo_reg[DIV_STAGES-1];

endmodule
`default_nettype wire

@@ hdl/lns_term.sv @@
`default_nettype none
module lns_term
    import lns_pkg::*;
#(
    parameter int ODD_INDEX = 1
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire logic              in_valid,
    input  wire side_t             in_side,
    input  wire logic [MAG_W-1:0]  in_power,
    input  wire logic [MAG_W-1:0]  in_e2,
    input  wire logic [SUM_W-1:0]  in_sum,
    output logic                   out_valid,
    output side_t                  out_side,
    output logic [MAG_W-1:0]       out_power,
    output logic [MAG_W-1:0]       out_e2,
    output logic [SUM_W-1:0]       out_sum
);

    // floor(p * RECIP / 2^31) is the true quotient or one below it.
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / ODD_INDEX);
    localparam logic [MAG_W-1:0]   DIVISOR = MAG_W'(ODD_INDEX);

    logic              a_valid_reg;
    side_t             a_side_reg;
    logic [MAG_W-1:0]  a_power_reg;
    logic [MAG_W-1:0]  a_next_power_reg;
    logic [MAG_W-1:0]  a_e2_reg;
    logic [SUM_W-1:0]  a_sum_reg;
    logic [MAG_W-1:0]  a_q0_reg;

    logic [MAG_W+RECIP_W-1:0] recip_prod;
    logic [2*MAG_W-1:0]       power_prod;
    logic [MAG_W-1:0]         q0_by_div;
    logic [MAG_W-1:0]         rem;
    logic [MAG_W-1:0]         quo;

    logic              b_valid_reg;
    side_t             b_side_reg;
    logic [MAG_W-1:0]  b_power_reg;
    logic [MAG_W-1:0]  b_e2_reg;
    logic [SUM_W-1:0]  b_sum_reg;

    assign recip_prod = {{RECIP_W{1'b0}}, in_power} * {{MAG_W{1'b0}}, RECIP};
    assign power_prod = {{MAG_W{1'b0}}, in_power} * {{MAG_W{1'b0}}, in_e2};

    assign q0_by_div = a_q0_reg * DIVISOR;
    assign rem       = a_power_reg - q0_by_div;
    assign quo       = (rem >= DIVISOR) ? a_q0_reg + MAG_W'(1) : a_q0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_side_reg       <= in_side;
            a_power_reg      <= in_power;
            a_next_power_reg <= power_prod[FRAC_E +: MAG_W];
            a_e2_reg         <= in_e2;
            a_sum_reg        <= in_sum;
            a_q0_reg         <= recip_prod[RECIP_SHIFT +: MAG_W];
            b_side_reg       <= a_side_reg;
            b_power_reg      <= a_next_power_reg;
            b_e2_reg         <= a_e2_reg;
            b_sum_reg        <= a_sum_reg + SUM_W'(quo);
        end
    end

    assign out_valid = b_valid_reg;
    assign out_side  = b_side_reg;
    assign out_power = b_power_reg;
    assign out_e2    = b_e2_reg;
    assign out_sum   = b_sum_reg;

endmodule
`default_nettype wire

@@ hdl/lns_checker.sv @@
`default_nettype none
module lns_checker
    import lns_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_ready,
    input wire logic [X_W-1:0]        x_value,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic [LOG_W-1:0]      log_value,
    input wire logic                  domain_error
);

    // A waiting input word stays offered and unchanged.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(x_value))
        else $error("input word dropped or changed while waiting");

    // A held result word keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(log_value) && $stable(domain_error))
        else $error("result word changed while stalled");

    // An error word carries a zero result.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && domain_error |-> log_value == '0)
        else $error("error word with nonzero result");

    // The pipeline accepts whenever the output register is empty.
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // Taking a result frees the pipeline for a new word in the same cycle.
    a_ready_take: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |-> in_ready)
        else $error("input stalled while result taken");

endmodule

bind natural_log_series_top lns_checker u_lns_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .x_value      (x_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .log_value    (log_value),
    .domain_error (domain_error)
);
`default_nettype wire

@@ bench/natural_log_series_top_test.sv @@
`default_nettype none
module natural_log_series_top_test;
    import lns_pkg::*;

    // The series length used by the instance; the predictor follows it.
    localparam int LAST_POWER = 25;
    // Pipeline depth, summed from the block's stages.
    localparam int LATENCY = 1 + 15 + 1 + 2 * ((LAST_POWER + 1) / 2) + 1;
    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [X_W-1:0] x_value;
    logic out_valid;
    logic out_ready;
    logic signed [LOG_W-1:0] log_value;
    logic domain_error;

    natural_log_series_top #(.LAST_ODD_POWER(LAST_POWER)) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .x_value(x_value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .log_value(log_value),
        .domain_error(domain_error)
    );

    // One expected result word, as the block should return it.
    typedef struct packed {
        logic [LOG_W-1:0] log_word;
        logic             err_flag;
    } log_result_t;

    log_result_t expected_logs[$];
    int  fail_count;
    int  cycle_count;
    // When set, neither side of the handshake idles (the closing part of the run).
    bit  steady_flow;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Predict ln(x) the way the block computes it: everything is done on the
    // magnitude of e in Q1.30, truncating toward zero, and the sign of x-1 is
    // applied at the end before saturation to the 20-bit result.
    function automatic log_result_t predict_log(logic [X_W-1:0] arg);
        log_result_t res;
        logic [63:0] diff;
        logic [63:0] mag;
        logic [63:0] e_sq;
        logic [63:0] pw;
        logic [63:0] acc;
        logic [63:0] lmag;
        logic        below;
        logic signed [63:0] val;
        res.log_word = '0;
        res.err_flag = 1'b0;
        if (arg[X_W-1] || arg == '0)
        begin
            res.err_flag = 1'b1;
            return res;
        end
        below = arg < ONE_Q16;
        diff = below ? (64'(ONE_Q16) - 64'(arg)) : (64'(arg) - 64'(ONE_Q16));
        mag = (diff << FRAC_E) / (64'(arg) + 64'(ONE_Q16));
        e_sq = (mag * mag) >> FRAC_E;
        pw = mag;
        acc = '0;
        for (int i = 1; i <= LAST_POWER; i += 2)
        begin
            acc += pw / 64'(i);
            pw = (pw * e_sq) >> FRAC_E;
        end
        lmag = (acc * 2) >> (FRAC_E - 16);
        if (below)
            val = (lmag > 64'd524288) ? -64'sd524288 : -$signed(lmag);
        else
            val = (lmag > 64'd524287) ? 64'sd524287 : $signed(lmag);
        res.log_word = val[LOG_W-1:0];
        return res;
    endfunction

    // Random idle burst, taken about one time in four;
    // the input is withdrawn only while idling.
    task automatic maybe_idle();
        if (!steady_flow && $urandom_range(3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge clk);
        end
    endtask

    // Send one word; the expectation is queued at the accepting edge.
    task automatic send_word(logic [X_W-1:0] arg);
        maybe_idle();
        in_valid <= 1'b1;
        x_value  <= arg;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_logs.push_back(predict_log(arg));
        @(negedge clk);
    endtask

    // The receiver stalls in bursts; results are checked at rising edges.
    always @(negedge clk)
    begin
        if (rst_n && !steady_flow && $urandom_range(4) == 0)
        begin
            out_ready <= 1'b0;
            repeat ($urandom_range(4, 1) - 1) @(negedge clk);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        log_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_logs.size() == 0)
            begin
                $error("result word with nothing expected: log_value %0d", log_value);
                fail_count++;
            end
            else
            begin
                want = expected_logs.pop_front();
                if (log_value !== want.log_word)
                begin
                    $error("log_value: expected %0d, actual %0d",
                           $signed(want.log_word), log_value);
                    fail_count++;
                end
                if (domain_error !== want.err_flag)
                begin
                    $error("domain_error: expected %0b, actual %0b",
                           want.err_flag, domain_error);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Boundary arguments: the error domain, exactly one, and both extremes.
    task automatic test_directed();
        logic [X_W-1:0] picks[$];
        picks = '{32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_0000,
                  32'h0001_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_FFFF,
                  32'h0001_0001, 32'h7FFF_FFFF, 32'h7FFF_0000, 32'h0002_0000,
                  32'h0000_8000, 32'h0002_B7E1, 32'h0000_5E2D, 32'h5555_5555,
                  32'hAAAA_AAAA, 32'h0000_0100, 32'h0100_0000, 32'h0000_0010};
        foreach (picks[i])
            send_word(picks[i]);
    endtask

    // Random arguments, weighted toward the valid domain with all scales.
    task automatic test_random(int count);
        logic [X_W-1:0] arg;
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(3))
                0: arg = $urandom;
                1: arg = $urandom >> $urandom_range(31);
                2: arg = ONE_Q16 + $urandom_range(2048) - 1024;
                default: arg = $urandom_range(32'h7FFF_FFFF);
            endcase
            send_word(arg);
        end
    endtask

    // The closing stretch runs with both sides always ready.
    task automatic test_full_rate(int count);
        steady_flow = 1'b1;
        test_random(count);
    endtask

    initial
    begin
        int waited;
        rst_n = 1'b0;
        in_valid = 1'b0;
        x_value = '0;
        out_ready = 1'b0;
        fail_count = 0;
        cycle_count = 0;
        steady_flow = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(1100);
        test_full_rate(200);
        in_valid <= 1'b0;

        waited = 0;
        while (expected_logs.size() != 0 && waited < 20 * LATENCY + 1000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (LATENCY + 4) @(posedge clk);
        if (expected_logs.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_logs.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire

@@ files.f @@
hdl/lns_pkg.sv
hdl/lns_divider.sv
hdl/lns_term.sv
hdl/natural_log_series_top.sv
hdl/lns_checker.sv
bench/natural_log_series_top_test.sv
